// File: rtl/wgm_pkg.sv
// Package for the wildcard glob matcher: sizes, pattern symbols, item kinds
// and the control word broadcast to the cell row. No dependencies.
package wgm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int POS_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int SUM_W = MAX_PATTERN + 2;

	localparam logic [7:0] STAR_SYM = 8'd42;
	localparam logic [7:0] ANY_SYM = 8'd63;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_SUBJECT = 2'd1,
		KIND_END = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		logic rearm;
		logic step;
		logic clear;
		logic [7:0] symbol;
	} cell_ctl_t;

endpackage

// File: rtl/wgm_cell.sv
// One pattern position: stored pattern byte, live bit and active bit.
// Hands its advance bit to the next cell. Uses wgm_pkg.
module wgm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  wgm_pkg::cell_ctl_t ctl,
	input  logic              wr,
	input  logic              head,
	input  logic              closed_in,
	input  logic              adv_in,
	output logic              adv_out,
	output logic              act,
	output logic              star
);
	import wgm_pkg::*;

	logic [7:0] char_q;
	logic       live_q;
	logic       act_q;
	logic       hit;
	logic       stay;

	always_ff @(posedge clk) begin
		if (wr) begin
			char_q <= ctl.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (ctl.clear) begin
			live_q <= 1'b0;
		end else if (wr) begin
			live_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= head;
		end else if (ctl.rearm) begin
			act_q <= head;
		end else if (ctl.step) begin
			act_q <= stay | adv_in;
		end
	end

	assign star    = live_q && (char_q == STAR_SYM);
	assign hit     = live_q && ((char_q == ANY_SYM) || (char_q == ctl.symbol));
	assign stay    = closed_in && star;
	assign adv_out = closed_in && hit && !star;
	assign act     = act_q;

endmodule

// File: rtl/wgm_closure.sv
// Star closure of the active set: a reached star position also reaches the
// next one, through whole runs of stars, done as one carry chain. Uses wgm_pkg.
module wgm_closure (
	input  logic [wgm_pkg::MAX_PATTERN:0]   raw,
	input  logic [wgm_pkg::MAX_PATTERN-1:0] star,
	output logic [wgm_pkg::MAX_PATTERN:0]   closed
);
	import wgm_pkg::*;

	logic [SUM_W-1:0] gen;
	logic [SUM_W-1:0] prop;
	logic [SUM_W-1:0] opa;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] carry;

	// carry out of bit j = gen[j] | prop[j] & carry into bit j
	assign gen    = {1'b0, raw};
	assign prop   = {1'b0, star, 1'b0};
	assign opa    = gen | prop;
	assign sum    = opa + gen;
	assign carry  = sum ^ opa ^ gen;
	assign closed = carry[SUM_W-1:1];

endmodule

// File: rtl/wildcard_glob_matcher.sv
// Wildcard glob matcher top level: item decode, pattern length, overflow
// flag, cell row, star closure and a two-word result buffer. Uses wgm_pkg,
// wgm_cell and wgm_closure.
//
//  channel  handshake            fields                       direction
//  in       in_valid / in_stall  kind[1:0], symbol[7:0]       into block
//  out      out_valid/ out_stall matched, pattern_overflow    out of block
//
// One word per cycle on every kind while in_stall is low; the step is one pass
// through the cell row and the closure carry chain, registered in the cells'
// active bits. An end-of-subject result is registered in a free result slot.
// Reset clears the pattern, the overflow flag and the buffer; no sweep.
// in_stall rises only when both result slots are full.
module wildcard_glob_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       pattern_overflow
);
	import wgm_pkg::*;

	logic                  accept;
	kind_t                 kind_w;
	logic                  is_append;
	logic                  is_subject;
	logic                  is_end;
	logic                  is_clear;
	logic                  full;
	logic                  app_ok;
	cell_ctl_t             ctl;
	logic [POS_W-1:0]      len_q;
	logic                  ovf_q;
	logic                  tail_q;
	logic [IDX_W-1:0]      idx;
	logic [MAX_PATTERN-1:0] wr;
	logic [MAX_PATTERN-1:0] act;
	logic [MAX_PATTERN-1:0] star;
	logic [MAX_PATTERN-1:0] adv;
	logic [MAX_PATTERN:0]  raw;
	logic [MAX_PATTERN:0]  closed;
	logic                  res_match;

	logic                  out_valid_q;
	logic                  res_match_q;
	logic                  res_ovf_q;
	logic                  skid_valid_q;
	logic                  skid_match_q;
	logic                  skid_ovf_q;
	logic                  out_fire;
	logic                  main_free;

	assign accept = in_valid && !in_stall;
	assign kind_w = kind_t'(kind);

	always_comb begin
		is_append  = 1'b0;
		is_subject = 1'b0;
		is_end     = 1'b0;
		is_clear   = 1'b0;
		unique case (kind_w)
			KIND_APPEND:  is_append = 1'b1;
			KIND_SUBJECT: is_subject = 1'b1;
			KIND_END:     is_end = 1'b1;
			KIND_CLEAR:   is_clear = 1'b1;
			default:      is_clear = 1'b1;
		endcase
	end

	assign full   = (len_q == POS_W'(MAX_PATTERN));
	assign app_ok = accept && is_append && !full;
	assign idx    = len_q[IDX_W-1:0];

	assign ctl.rearm  = accept && !is_subject;
	assign ctl.step   = accept && is_subject;
	assign ctl.clear  = accept && is_clear;
	assign ctl.symbol = symbol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.clear) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (app_ok) begin
			len_q <= len_q + POS_W'(1);
		end else if (accept && is_append) begin
			ovf_q <= 1'b1;
		end
	end

	// active bit of the position past the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else if (ctl.rearm) begin
			tail_q <= 1'b0;
		end else if (ctl.step) begin
			tail_q <= adv[MAX_PATTERN-1];
		end
	end

	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		assign wr[g] = app_ok && (idx == IDX_W'(g));
		wgm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.wr        (wr[g]),
			.head      ((g == 0) ? 1'b1 : 1'b0),
			.closed_in (closed[g]),
			.adv_in    ((g == 0) ? 1'b0 : adv[(g == 0) ? 0 : g - 1]),
			.adv_out   (adv[g]),
			.act       (act[g]),
			.star      (star[g])
		);
	end

	assign raw = {tail_q, act};

	wgm_closure u_closure (
		.raw    (raw),
		.star   (star),
		.closed (closed)
	);

	assign res_match = closed[len_q];

	// result buffer: main word plus one skid word
	assign out_fire  = out_valid_q && !out_stall;
	assign main_free = !out_valid_q || (out_fire && !skid_valid_q);
	assign in_stall  = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire && skid_valid_q) begin
			skid_valid_q <= 1'b0;
		end else if (accept && is_end) begin
			if (main_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire && skid_valid_q) begin
			res_match_q <= skid_match_q;
			res_ovf_q   <= skid_ovf_q;
		end else if (accept && is_end) begin
			if (main_free) begin
				res_match_q <= res_match;
				res_ovf_q   <= ovf_q;
			end else begin
				skid_match_q <= res_match;
				skid_ovf_q   <= ovf_q;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = res_match_q;
	assign pattern_overflow = res_ovf_q;

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without a main word");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= POS_W'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_clear) |=> (len_q == '0) && !ovf_q)
		else $error("clear left pattern state behind");

	a_end_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_end) |=> out_valid_q)
		else $error("end of subject produced no result word");

	a_rearm_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rearm |=> act[0] && !tail_q)
		else $error("rearm did not restore position zero");

endmodule

// File: sim/wgm_match_checker.sv
// Match checker for the wildcard glob matcher: follows the pattern store and
// the set of reachable pattern positions word by word, queues the verdict each
// end-of-subject word should produce and compares it with the result channel.
// Depends on wgm_pkg.
module wgm_match_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] symbol,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       matched,
	input  logic       pattern_overflow,
	output int         mismatches,
	output int         pending
);
	import wgm_pkg::*;

	localparam logic [MAX_PATTERN:0] START_SET = (MAX_PATTERN + 1)'(1);

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic [7:0]         pat_mem [0:MAX_PATTERN-1];
	int                 pat_len;
	logic [MAX_PATTERN:0] live;
	logic               ovf;
	verdict_t           verdict_q [$];
	verdict_t           want;
	int                 miss_cnt;

	assign mismatches = miss_cnt;

	// a star at i also makes i+1 reachable
	function automatic logic [MAX_PATTERN:0] star_closure(logic [MAX_PATTERN:0] s);
		for (int i = 0; i < pat_len; i++)
			if (s[i] && pat_mem[i] == STAR_SYM)
				s[i+1] = 1'b1;
		return s;
	endfunction

	function automatic logic [MAX_PATTERN:0] advance_on_byte(logic [MAX_PATTERN:0] cur,
		logic [7:0] c);
		logic [MAX_PATTERN:0] nxt;
		cur = star_closure(cur);
		nxt = '0;
		for (int i = 0; i < pat_len; i++) begin
			if (cur[i]) begin
				if (pat_mem[i] == STAR_SYM)
					nxt[i] = 1'b1;
				else if (pat_mem[i] == ANY_SYM || pat_mem[i] == c)
					nxt[i+1] = 1'b1;
			end
		end
		return nxt;
	endfunction

	initial begin
		miss_cnt = 0;
		pending <= 0;
		pat_len = 0;
		ovf = 1'b0;
		live = START_SET;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len = 0;
			ovf = 1'b0;
			live = START_SET;
			verdict_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					miss_cnt++;
					$display("%0t: result word with none expected: matched %0b overflow %0b",
						$time, matched, pattern_overflow);
				end else begin
					want = verdict_q.pop_front();
					if (matched !== want.matched) begin
						miss_cnt++;
						$display("%0t: matched expected %0b got %0b",
							$time, want.matched, matched);
					end
					if (pattern_overflow !== want.overflow) begin
						miss_cnt++;
						$display("%0t: pattern_overflow expected %0b got %0b",
							$time, want.overflow, pattern_overflow);
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (kind_t'(kind))
					KIND_APPEND: begin
						if (pat_len < MAX_PATTERN) begin
							pat_mem[pat_len] = symbol;
							pat_len++;
						end else begin
							ovf = 1'b1;
						end
						live = START_SET;
					end
					KIND_SUBJECT: begin
						live = advance_on_byte(live, symbol);
					end
					KIND_END: begin
						live = star_closure(live);
						verdict_q.push_back(verdict_t'{matched: live[pat_len], overflow: ovf});
						live = START_SET;
					end
					KIND_CLEAR: begin
						pat_len = 0;
						ovf = 1'b0;
						live = START_SET;
					end
				endcase
			end
			pending <= verdict_q.size();
		end
	end

endmodule

// File: sim/wildcard_glob_matcher_test.sv
// Testbench top for the wildcard glob matcher: drives pattern, subject, end
// and clear words with bursty timing and a stalling receiver, and gives the
// verdict. Depends on wgm_pkg, wildcard_glob_matcher and wgm_match_checker.
module wildcard_glob_matcher_test;
	import wgm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int WORD_TARGET = 600;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] kind;
	logic [7:0] symbol;
	logic       out_valid;
	logic       out_stall;
	logic       matched;
	logic       pattern_overflow;
	int         mismatches;
	int         pending;
	int         cycles;
	int         words_sent;
	int         burst_left;
	logic       hold_req;

	wildcard_glob_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.symbol(symbol),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.matched(matched),
		.pattern_overflow(pattern_overflow)
	);

	wgm_match_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.symbol(symbol),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.matched(matched),
		.pattern_overflow(pattern_overflow),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// mostly a small alphabet so that subjects hit the pattern
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'h61 + 8'($urandom_range(0, 2));
	endfunction

	task automatic send_word(input kind_t k, input logic [7:0] s);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		kind <= k;
		symbol <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	// receiver: stall pattern changes per span, one long hold-off on request
	initial begin
		int  mode;
		int  span;
		bit  held;
		held = 0;
		out_stall = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 120);
			for (int j = 0; j < span; j++) begin
				@(posedge clk);
				if (hold_req && !held) begin
					held = 1;
					out_stall <= 1'b1;
					repeat (150) @(posedge clk);
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 75);
					default: out_stall <= (j % 4 != 0);
				endcase
			end
		end
	end

	initial begin
		logic [7:0] pat_q [$];
		logic [7:0] subj_q [$];
		logic [7:0] c;
		int         n_pat;
		int         r;
		int         idx;
		in_valid = 1'b0;
		kind = KIND_APPEND;
		symbol = 8'd0;
		hold_req = 1'b0;
		words_sent = 0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern vs empty subject, then a non-empty subject
		send_word(KIND_END, 8'd0);
		send_word(KIND_SUBJECT, 8'h61);
		send_word(KIND_END, 8'hFF);
		// lone star matches the empty subject
		send_word(KIND_APPEND, STAR_SYM);
		send_word(KIND_END, 8'd0);
		// "*?" against byte zero
		send_word(KIND_APPEND, ANY_SYM);
		send_word(KIND_SUBJECT, 8'd0);
		send_word(KIND_END, 8'd0);
		// "*?\xff" against "\xff\xff"
		send_word(KIND_APPEND, 8'hFF);
		send_word(KIND_SUBJECT, 8'hFF);
		send_word(KIND_SUBJECT, 8'hFF);
		send_word(KIND_END, 8'd0);
		// append in mid subject re-arms
		send_word(KIND_SUBJECT, 8'h78);
		send_word(KIND_APPEND, 8'h62);
		send_word(KIND_SUBJECT, 8'h01);
		send_word(KIND_SUBJECT, 8'hFF);
		send_word(KIND_SUBJECT, 8'h62);
		send_word(KIND_END, 8'hFF);
		// clear in mid subject
		send_word(KIND_SUBJECT, 8'h71);
		send_word(KIND_CLEAR, 8'hFF);
		send_word(KIND_END, 8'd0);

		// back-pressure: receiver holds off while ends keep coming
		hold_req <= 1'b1;
		repeat (30) send_word(KIND_END, 8'($urandom_range(0, 255)));

		while (words_sent < WORD_TARGET) begin
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 4))
					send_word(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				send_word(KIND_CLEAR, 8'($urandom_range(0, 255)));
				pat_q.delete();
				n_pat = ($urandom_range(0, 6) == 0) ? $urandom_range(28, 36)
					: $urandom_range(0, 8);
				for (int i = 0; i < n_pat; i++) begin
					r = $urandom_range(0, 9);
					c = (r < 3) ? STAR_SYM : (r < 5) ? ANY_SYM : pick_byte();
					send_word(KIND_APPEND, c);
					if (pat_q.size() < MAX_PATTERN)
						pat_q.push_back(c);
				end
				repeat ($urandom_range(1, 4)) begin
					subj_q.delete();
					for (int i = 0; i < pat_q.size(); i++) begin
						if (pat_q[i] == STAR_SYM)
							repeat ($urandom_range(0, 3)) subj_q.push_back(pick_byte());
						else if (pat_q[i] == ANY_SYM)
							subj_q.push_back(pick_byte());
						else
							subj_q.push_back(pat_q[i]);
					end
					// spoil about a quarter of the subjects
					if ($urandom_range(0, 3) == 0 && subj_q.size() > 0) begin
						idx = $urandom_range(0, subj_q.size() - 1);
						case ($urandom_range(0, 2))
							0: subj_q.delete(idx);
							1: subj_q.insert(idx, pick_byte());
							default: subj_q[idx] = pick_byte();
						endcase
					end
					for (int i = 0; i < subj_q.size(); i++)
						send_word(KIND_SUBJECT, subj_q[i]);
					send_word(KIND_END, 8'($urandom_range(0, 255)));
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
